// ===== hdl/sspoc_pkg.sv =====
// ----------------------------------------------------------------------------
// sspoc_pkg: shared types and constants
// item classes, payload structs, timing constants and the big-step table
// ----------------------------------------------------------------------------
package sspoc_pkg;

  localparam logic [15:0] BLINK_PERIOD_MS = 16'd500;
  localparam logic [15:0] BIG_STEP_PERIOD_MS = 16'd100;
  localparam logic [15:0] DOUBLE_PRESS_MS = 16'd1000;
  localparam logic [15:0] RECOVERY_PERIOD_MS = 16'd1000;
  localparam logic [15:0] RAMP_UP_MS = 16'd500;
  localparam logic [15:0] LOW_VOLTAGE_MV = 16'd500;
  localparam logic [3:0]  LOW_READINGS = 4'd10;

  localparam logic [15:0] VOLTAGE_MIN_RST = 16'd3300;
  localparam logic [15:0] VOLTAGE_MAX_RST = 16'd21000;
  localparam logic [7:0]  VOLTAGE_STEP_RST = 8'd20;
  localparam logic [15:0] CURRENT_MIN_RST = 16'd1000;
  localparam logic [15:0] CURRENT_MAX_RST = 16'd3000;
  localparam logic [7:0]  CURRENT_STEP_RST = 8'd50;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_KNOB   = 3'd1,
    MODE_SAMPLE = 3'd2,
    MODE_FAULT  = 3'd3,
    MODE_OFF    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    KNOB_IDLE  = 3'd0,
    KNOB_SHORT = 3'd1,
    KNOB_LONG  = 3'd2,
    KNOB_UP    = 3'd3,
    KNOB_DOWN  = 3'd4
  } knob_t;

  typedef enum logic [2:0] {
    REG_VOLTAGE_MIN  = 3'd0,
    REG_VOLTAGE_MAX  = 3'd1,
    REG_VOLTAGE_STEP = 3'd2,
    REG_CURRENT_MIN  = 3'd3,
    REG_CURRENT_MAX  = 3'd4,
    REG_CURRENT_STEP = 3'd5,
    REG_EDIT_ALLOWED = 3'd6,
    REG_MENU_ALLOWED = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    SEL_NONE    = 2'd0,
    SEL_VOLTAGE = 2'd1,
    SEL_CURRENT = 2'd2
  } sel_t;

  typedef enum logic [3:0] {
    CL_NONE, CL_TICK, CL_PRESS, CL_LONG, CL_UP, CL_DOWN, CL_SAMPLE, CL_FAULT, CL_OFF
  } item_class_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_MUL, BK_UPD
  } back_state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  elapsed_ms;
    logic [2:0]  knob_event;
    logic [15:0] sample_mv;
    logic        fault_present;
  } in_item_t;

  typedef struct packed {
    logic        output_on;
    logic [15:0] set_voltage_mv;
    logic [15:0] set_current_ma;
    logic [1:0]  selected_field;
    logic        editing;
    logic        fault_latched;
    logic        apply_request;
    logic        menu_request;
    logic        volt_hl;
    logic        curr_hl;
  } out_item_t;

  typedef struct packed {
    item_class_t cls;
    logic [7:0]  elapsed_ms;
    logic [15:0] sample_mv;
    logic        fault_present;
  } work_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_ctl_t;

  // detents per big step: 250 / step, with a zero step counted as one
  function automatic logic [7:0] big_count(input logic [7:0] step);
    logic [7:0] c;
    case (step) inside
      8'd0:          c = 8'd1;
      8'd1:          c = 8'd250;
      8'd2:          c = 8'd125;
      8'd3:          c = 8'd83;
      8'd4:          c = 8'd62;
      8'd5:          c = 8'd50;
      8'd6:          c = 8'd41;
      8'd7:          c = 8'd35;
      8'd8:          c = 8'd31;
      8'd9:          c = 8'd27;
      8'd10:         c = 8'd25;
      8'd11:         c = 8'd22;
      8'd12:         c = 8'd20;
      8'd13:         c = 8'd19;
      8'd14:         c = 8'd17;
      8'd15:         c = 8'd16;
      8'd16:         c = 8'd15;
      8'd17:         c = 8'd14;
      [8'd18:8'd19]: c = 8'd13;
      8'd20:         c = 8'd12;
      [8'd21:8'd22]: c = 8'd11;
      [8'd23:8'd25]: c = 8'd10;
      [8'd26:8'd27]: c = 8'd9;
      [8'd28:8'd31]: c = 8'd8;
      [8'd32:8'd35]: c = 8'd7;
      [8'd36:8'd41]: c = 8'd6;
      [8'd42:8'd50]: c = 8'd5;
      [8'd51:8'd62]: c = 8'd4;
      [8'd63:8'd83]: c = 8'd3;
      [8'd84:8'd125]: c = 8'd2;
      [8'd126:8'd250]: c = 8'd1;
      default:       c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] t, input logic [7:0] d);
    logic [16:0] s;
    s = {1'b0, t} + {9'd0, d};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// ===== hdl/sspoc_front.sv =====
// ----------------------------------------------------------------------------
// sspoc_front: input classifier
// decodes mode and knob code of each accepted beat into one work class
// ----------------------------------------------------------------------------
module sspoc_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  sspoc_pkg::in_item_t in_data,
  input  logic                q_full,
  output logic                q_push,
  output sspoc_pkg::work_t    q_data
);

  sspoc_pkg::item_class_t cls;

  always_comb begin
    cls = sspoc_pkg::CL_NONE;
    case (in_data.mode)
      sspoc_pkg::MODE_TICK:   cls = sspoc_pkg::CL_TICK;
      sspoc_pkg::MODE_SAMPLE: cls = sspoc_pkg::CL_SAMPLE;
      sspoc_pkg::MODE_OFF:    cls = sspoc_pkg::CL_OFF;
      sspoc_pkg::MODE_FAULT: begin
        if (in_data.fault_present) cls = sspoc_pkg::CL_FAULT;
      end
      sspoc_pkg::MODE_KNOB: begin
        case (in_data.knob_event)
          sspoc_pkg::KNOB_SHORT: cls = sspoc_pkg::CL_PRESS;
          sspoc_pkg::KNOB_LONG:  cls = sspoc_pkg::CL_LONG;
          sspoc_pkg::KNOB_UP:    cls = sspoc_pkg::CL_UP;
          sspoc_pkg::KNOB_DOWN:  cls = sspoc_pkg::CL_DOWN;
          default:               cls = sspoc_pkg::CL_NONE;
        endcase
      end
      default: cls = sspoc_pkg::CL_NONE;
    endcase
  end

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;
  assign q_data = '{cls: cls, elapsed_ms: in_data.elapsed_ms,
                    sample_mv: in_data.sample_mv, fault_present: in_data.fault_present};

endmodule

// ===== hdl/sspoc_queue.sv =====
// ----------------------------------------------------------------------------
// sspoc_queue: two-entry work queue
// decouples the classifier from the state update engine
// ----------------------------------------------------------------------------
module sspoc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sspoc_pkg::work_t       wr_data,
  input  logic                   pop,
  output sspoc_pkg::work_t       rd_data,
  output sspoc_pkg::queue_ctl_t  ctl
);

  localparam int PW = $clog2(sspoc_pkg::QUEUE_DEPTH);

  sspoc_pkg::work_t entries [sspoc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic full, empty, do_push, do_pop;

  assign full = (count == (PW+1)'(sspoc_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_data = entries[rd_ptr];
  assign ctl = '{push: do_push, pop: do_pop, full: full, empty: empty};

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(sspoc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PW'(sspoc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

// ===== hdl/sspoc_back.sv =====
// ----------------------------------------------------------------------------
// sspoc_back: state update engine
// holds config and panel state, applies one work item, registers the result
// ----------------------------------------------------------------------------
module sspoc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  sspoc_pkg::queue_ctl_t  q_ctl,
  input  sspoc_pkg::work_t       q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sspoc_pkg::out_item_t   out_data
);

  // config registers
  logic [15:0] volt_lo, volt_hi, curr_lo, curr_hi;
  logic [7:0]  volt_inc, curr_inc;
  logic        editing_allowed, menu_allowed;

  // panel state
  logic [15:0] voltage_sp, current_sp, blink_timer, knob_timer, recovery_timer, ramp_timer;
  logic [15:0] last_sample;
  logic [1:0]  selection;
  logic [3:0]  low_count;
  logic        edit_flag, blink_phase, output_flag, fault_flag;

  sspoc_pkg::back_state_t state, state_next;
  sspoc_pkg::work_t cur;
  logic [15:0] delta;
  logic out_free, do_update;

  // next-state values
  logic [15:0] voltage_sp_next, current_sp_next, blink_timer_next, knob_timer_next;
  logic [15:0] recovery_timer_next, ramp_timer_next, last_sample_next;
  logic [1:0]  selection_next;
  logic [3:0]  low_count_next;
  logic        edit_flag_next, blink_phase_next, output_flag_next, fault_flag_next;
  logic        apply, menu, active;
  logic [7:0]  step_sel;
  logic [15:0] val_sel, lo_sel, hi_sel, adj;
  logic signed [17:0] sum;

  assign out_free = !out_valid || !out_stall;
  assign do_update = (state == sspoc_pkg::BK_UPD) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      sspoc_pkg::BK_IDLE: if (!q_ctl.empty) state_next = sspoc_pkg::BK_MUL;
      sspoc_pkg::BK_MUL:  state_next = sspoc_pkg::BK_UPD;
      sspoc_pkg::BK_UPD:  if (out_free) state_next = sspoc_pkg::BK_IDLE;
      default:            state_next = sspoc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    case (state)
      sspoc_pkg::BK_IDLE: q_pop = !q_ctl.empty;
      default:            q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sspoc_pkg::BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  // step times detent count on a fast turn, else bare step; registered
  always_comb begin
    step_sel = (selection == sspoc_pkg::SEL_CURRENT) ? curr_inc : volt_inc;
  end

  always_ff @(posedge clk) begin
    if (state == sspoc_pkg::BK_MUL) begin
      if (knob_timer < sspoc_pkg::BIG_STEP_PERIOD_MS)
        delta <= step_sel * sspoc_pkg::big_count(step_sel);
      else
        delta <= {8'd0, step_sel};
    end
  end

  // add and clamp, maximum first so the minimum wins on crossed limits
  always_comb begin
    val_sel = (selection == sspoc_pkg::SEL_CURRENT) ? current_sp : voltage_sp;
    lo_sel = (selection == sspoc_pkg::SEL_CURRENT) ? curr_lo : volt_lo;
    hi_sel = (selection == sspoc_pkg::SEL_CURRENT) ? curr_hi : volt_hi;
    if (cur.cls == sspoc_pkg::CL_UP)
      sum = $signed({2'b00, val_sel}) + $signed({2'b00, delta});
    else
      sum = $signed({2'b00, val_sel}) - $signed({2'b00, delta});
    if (sum > $signed({2'b00, hi_sel})) sum = $signed({2'b00, hi_sel});
    if (sum < $signed({2'b00, lo_sel})) sum = $signed({2'b00, lo_sel});
    adj = sum[15:0];
  end

  always_comb begin
    voltage_sp_next = voltage_sp;
    current_sp_next = current_sp;
    blink_timer_next = blink_timer;
    knob_timer_next = knob_timer;
    recovery_timer_next = recovery_timer;
    ramp_timer_next = ramp_timer;
    last_sample_next = last_sample;
    selection_next = selection;
    low_count_next = low_count;
    edit_flag_next = edit_flag;
    blink_phase_next = blink_phase;
    output_flag_next = output_flag;
    fault_flag_next = fault_flag;
    apply = 1'b0;
    menu = 1'b0;
    case (cur.cls)
      sspoc_pkg::CL_TICK: begin
        blink_timer_next = sspoc_pkg::sat_add(blink_timer, cur.elapsed_ms);
        knob_timer_next = sspoc_pkg::sat_add(knob_timer, cur.elapsed_ms);
        recovery_timer_next = sspoc_pkg::sat_add(recovery_timer, cur.elapsed_ms);
        ramp_timer_next = sspoc_pkg::sat_add(ramp_timer, cur.elapsed_ms);
        if (edit_flag && blink_timer_next >= sspoc_pkg::BLINK_PERIOD_MS) begin
          blink_timer_next = '0;
          blink_phase_next = !blink_phase;
        end
        if (fault_flag && recovery_timer_next >= sspoc_pkg::RECOVERY_PERIOD_MS) begin
          recovery_timer_next = '0;
          if (!cur.fault_present) begin
            fault_flag_next = 1'b0;
            apply = 1'b1;
          end
        end
        if (ramp_timer_next >= sspoc_pkg::RAMP_UP_MS && output_flag &&
            last_sample < sspoc_pkg::LOW_VOLTAGE_MV) begin
          low_count_next = low_count + 4'd1;
          if (low_count_next >= sspoc_pkg::LOW_READINGS) begin
            output_flag_next = 1'b0;
            low_count_next = '0;
          end
        end
      end
      sspoc_pkg::CL_PRESS: begin
        if (selection != sspoc_pkg::SEL_NONE) begin
          apply = edit_flag;
          edit_flag_next = !edit_flag;
        end else if (menu_allowed && !output_flag) begin
          if (knob_timer <= sspoc_pkg::DOUBLE_PRESS_MS) menu = 1'b1;
          else knob_timer_next = '0;
        end
      end
      sspoc_pkg::CL_LONG: begin
        if (!edit_flag && !fault_flag) begin
          output_flag_next = !output_flag;
          ramp_timer_next = '0;
        end
      end
      sspoc_pkg::CL_UP, sspoc_pkg::CL_DOWN: begin
        if (editing_allowed) begin
          if (edit_flag) begin
            knob_timer_next = '0;
            if (selection == sspoc_pkg::SEL_VOLTAGE) voltage_sp_next = adj;
            else if (selection == sspoc_pkg::SEL_CURRENT) current_sp_next = adj;
          end else if (cur.cls == sspoc_pkg::CL_UP) begin
            selection_next = (selection == sspoc_pkg::SEL_CURRENT) ? sspoc_pkg::SEL_NONE
                                                                   : selection + 2'd1;
          end else begin
            selection_next = (selection == sspoc_pkg::SEL_NONE) ? sspoc_pkg::SEL_CURRENT
                                                                : selection - 2'd1;
          end
        end
      end
      sspoc_pkg::CL_SAMPLE: last_sample_next = cur.sample_mv;
      sspoc_pkg::CL_FAULT: begin
        fault_flag_next = 1'b1;
        output_flag_next = 1'b0;
      end
      sspoc_pkg::CL_OFF: output_flag_next = 1'b0;
      default: ;
    endcase
    active = edit_flag_next ? blink_phase_next : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_lo <= sspoc_pkg::VOLTAGE_MIN_RST;
      volt_hi <= sspoc_pkg::VOLTAGE_MAX_RST;
      volt_inc <= sspoc_pkg::VOLTAGE_STEP_RST;
      curr_lo <= sspoc_pkg::CURRENT_MIN_RST;
      curr_hi <= sspoc_pkg::CURRENT_MAX_RST;
      curr_inc <= sspoc_pkg::CURRENT_STEP_RST;
      editing_allowed <= 1'b0;
      menu_allowed <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sspoc_pkg::REG_VOLTAGE_MIN:  volt_lo <= cfg_data;
        sspoc_pkg::REG_VOLTAGE_MAX:  volt_hi <= cfg_data;
        sspoc_pkg::REG_VOLTAGE_STEP: volt_inc <= cfg_data[7:0];
        sspoc_pkg::REG_CURRENT_MIN:  curr_lo <= cfg_data;
        sspoc_pkg::REG_CURRENT_MAX:  curr_hi <= cfg_data;
        sspoc_pkg::REG_CURRENT_STEP: curr_inc <= cfg_data[7:0];
        sspoc_pkg::REG_EDIT_ALLOWED: editing_allowed <= cfg_data[0];
        sspoc_pkg::REG_MENU_ALLOWED: menu_allowed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_sp <= sspoc_pkg::VOLTAGE_MIN_RST;
      current_sp <= sspoc_pkg::CURRENT_MIN_RST;
      blink_timer <= '0;
      knob_timer <= '0;
      recovery_timer <= '0;
      ramp_timer <= '0;
      last_sample <= '0;
      selection <= sspoc_pkg::SEL_NONE;
      low_count <= '0;
      edit_flag <= 1'b0;
      blink_phase <= 1'b0;
      output_flag <= 1'b0;
      fault_flag <= 1'b0;
    end else if (do_update) begin
      voltage_sp <= voltage_sp_next;
      current_sp <= current_sp_next;
      blink_timer <= blink_timer_next;
      knob_timer <= knob_timer_next;
      recovery_timer <= recovery_timer_next;
      ramp_timer <= ramp_timer_next;
      last_sample <= last_sample_next;
      selection <= selection_next;
      low_count <= low_count_next;
      edit_flag <= edit_flag_next;
      blink_phase <= blink_phase_next;
      output_flag <= output_flag_next;
      fault_flag <= fault_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (do_update) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      out_data.output_on <= output_flag_next;
      out_data.set_voltage_mv <= voltage_sp_next;
      out_data.set_current_ma <= current_sp_next;
      out_data.selected_field <= selection_next;
      out_data.editing <= edit_flag_next;
      out_data.fault_latched <= fault_flag_next;
      out_data.apply_request <= apply;
      out_data.menu_request <= menu;
      out_data.volt_hl <= (selection_next == sspoc_pkg::SEL_VOLTAGE) && active;
      out_data.curr_hl <= (selection_next == sspoc_pkg::SEL_CURRENT) && active;
    end
  end

endmodule

// ===== hdl/supply_setpoint_output_controller.sv =====
// ----------------------------------------------------------------------------
// supply_setpoint_output_controller: front-panel controller top level
// setpoint editing, selection, blink, menu request and output switching
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid / in_stall / in_data carries one event per beat:
//   a tick, a knob event, a voltage sample, a fault report or an off report
//   output channel out_valid / out_stall / out_data gives exactly one result
//   beat per input beat, in order: output switch, setpoints, selection,
//   edit and fault flags, apply and menu pulses, highlights
//   configuration registers are written through cfg_we / cfg_index / cfg_data
//   only while no item is in flight, a rule for the user that the block leaves unenforced
// processing
//   an accepted beat sits in a two-entry queue, then the update engine
//   takes it through its states in order (pop, step multiply,
//   add-clamp-update, which waits on a stalled output); the engine
//   takes no new item from the queue until it is through with the last
// reset
//   rst is synchronous; it empties the queue, drops out_valid and loads the
//   register reset values, with the setpoints at the minimum limits
// stalls
//   a stalled result holds in the output register; the engine waits, the
//   queue fills, and in_stall rises once both queue entries are taken
// ----------------------------------------------------------------------------
module supply_setpoint_output_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sspoc_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sspoc_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  // classified work between front and back
  sspoc_pkg::work_t      push_item, pop_item;
  sspoc_pkg::queue_ctl_t q_ctl;
  logic                  q_push, q_pop;

  sspoc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_ctl.full),
    .q_push   (q_push),
    .q_data   (push_item)
  );

  sspoc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (push_item),
    .pop     (q_pop),
    .rd_data (pop_item),
    .ctl     (q_ctl)
  );

  // engine owns the config registers and all panel state
  sspoc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_ctl     (q_ctl),
    .q_data    (pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/sspoc_checker.sv =====
// ----------------------------------------------------------------------------
// sspoc_checker: port-level checks
// consistency of result beats as seen on the top-level ports
// ----------------------------------------------------------------------------
module sspoc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input sspoc_pkg::out_item_t  out_data
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // editing only happens with a field selected
  a_edit_sel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.editing |-> out_data.selected_field != sspoc_pkg::SEL_NONE)
    else $error("editing without selection");

  // highlights follow the selected field
  a_highlight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.volt_hl || out_data.selected_field == sspoc_pkg::SEL_VOLTAGE) &&
                  (!out_data.curr_hl || out_data.selected_field == sspoc_pkg::SEL_CURRENT))
    else $error("highlight on unselected field");

  // menu pulse only with output off, nothing selected and no apply pulse
  a_menu: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.menu_request |->
      !out_data.output_on && out_data.selected_field == sspoc_pkg::SEL_NONE &&
      !out_data.apply_request)
    else $error("menu request in wrong state");

endmodule

bind supply_setpoint_output_controller sspoc_checker u_sspoc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
